>>> hdl/cci_pkg.sv
// Shared types and constants for the cubic curve interpolator.
// Holds payload structs, command codes and the datapath widths used by every stage.
// No dependencies.
`default_nettype none

package cci_pkg;

  // Coordinate format: signed Q(COORD_WIDTH-FRAC_BITS).FRAC_BITS
  localparam int COORD_WIDTH = 32;
  localparam int FRAC_BITS   = 16;

  // Basis factors reach 3*2^FRAC_BITS
  localparam int FACT_WIDTH  = FRAC_BITS + 2;
  // Exact weighted sum, weights scaled by 2^(3*FRAC_BITS), with headroom for four terms
  localparam int ACC_WIDTH   = COORD_WIDTH + 3 * FRAC_BITS + 3;
  // Sum after dropping 2*FRAC_BITS fraction bits
  localparam int QUOT_WIDTH  = ACC_WIDTH - 2 * FRAC_BITS;

  // factor prep, three multiplies, pair sum, total/round, saturate
  localparam int NUM_STAGES  = 7;
  localparam int NUM_TERMS   = 4;

  typedef enum logic [1:0] {
    CMD_LERP    = 2'd0,
    CMD_BEZIER  = 2'd1,
    CMD_HERMITE = 2'd2
  } cmd_e;

  typedef struct packed {
    logic [1:0]                    command;
    logic signed [COORD_WIDTH-1:0] point_a;
    logic signed [COORD_WIDTH-1:0] point_b;
    logic signed [COORD_WIDTH-1:0] point_c;
    logic signed [COORD_WIDTH-1:0] point_d;
    logic [FRAC_BITS:0]            blend;
  } cci_in_t;

  typedef struct packed {
    logic signed [COORD_WIDTH-1:0] value;
    logic                          clipped;
  } cci_out_t;

  // One weighted term: coordinate (possibly negated) times f1*f2*f3
  typedef struct packed {
    logic signed [COORD_WIDTH:0] coord;
    logic [FACT_WIDTH-1:0]       f1;
    logic [FACT_WIDTH-1:0]       f2;
    logic [FACT_WIDTH-1:0]       f3;
  } cci_term_t;

  typedef logic signed [ACC_WIDTH-1:0] acc_t;

endpackage

`default_nettype wire

>>> hdl/cci_weights.sv
// First pipeline stage: clamps t, forms U = 1 - t and the three basis factors per term.
// Depends on cci_pkg.
`default_nettype none

module cci_weights (
  input  wire logic                            clk,
  input  wire logic                            ld,
  input  wire cci_pkg::cci_in_t                item,
  output cci_pkg::cci_term_t [cci_pkg::NUM_TERMS-1:0] terms
);
  import cci_pkg::*;

  localparam logic [FACT_WIDTH-1:0] ONE = {2'b01, {FRAC_BITS{1'b0}}};

  logic [FACT_WIDTH-1:0] t;
  logic [FACT_WIDTH-1:0] u;
  logic [FACT_WIDTH-1:0] t3;
  logic [FACT_WIDTH-1:0] one_2t;
  logic [FACT_WIDTH-1:0] three_2t;
  logic signed [COORD_WIDTH:0] ca;
  logic signed [COORD_WIDTH:0] cb;
  logic signed [COORD_WIDTH:0] cc;
  logic signed [COORD_WIDTH:0] cd;
  cci_term_t [NUM_TERMS-1:0] terms_next;

  always_comb begin
    if ({1'b0, item.blend} > ONE) begin
      t = ONE;
    end else begin
      t = {1'b0, item.blend};
    end
    u        = ONE - t;
    t3       = t + (t << 1);
    one_2t   = ONE + (t << 1);
    three_2t = ONE + (ONE << 1) - (t << 1);

    ca = {item.point_a[COORD_WIDTH-1], item.point_a};
    cb = {item.point_b[COORD_WIDTH-1], item.point_b};
    cc = {item.point_c[COORD_WIDTH-1], item.point_c};
    cd = {item.point_d[COORD_WIDTH-1], item.point_d};

    // zero factors give a zero term; the unused command ends up as zero overall
    terms_next[0] = '{coord: ca, f1: '0, f2: '0, f3: '0};
    terms_next[1] = '{coord: cb, f1: '0, f2: '0, f3: '0};
    terms_next[2] = '{coord: cc, f1: '0, f2: '0, f3: '0};
    terms_next[3] = '{coord: cd, f1: '0, f2: '0, f3: '0};

    case (item.command)
      CMD_LERP: begin
        terms_next[0] = '{coord: ca, f1: u, f2: ONE, f3: ONE};
        terms_next[1] = '{coord: cb, f1: t, f2: ONE, f3: ONE};
      end
      CMD_BEZIER: begin
        terms_next[0] = '{coord: ca, f1: u,  f2: u, f3: u};
        terms_next[1] = '{coord: cb, f1: t3, f2: u, f3: u};
        terms_next[2] = '{coord: cc, f1: t3, f2: t, f3: u};
        terms_next[3] = '{coord: cd, f1: t,  f2: t, f3: t};
      end
      CMD_HERMITE: begin
        terms_next[0] = '{coord: ca, f1: u, f2: u, f3: one_2t};
        terms_next[1] = '{coord: cb, f1: t, f2: u, f3: u};
        // in-tangent weight is negative
        terms_next[2] = '{coord: -cc, f1: t, f2: t, f3: u};
        terms_next[3] = '{coord: cd, f1: t, f2: t, f3: three_2t};
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (ld) begin
      terms <= terms_next;
    end
  end

endmodule

`default_nettype wire

>>> hdl/cci_term_mul.sv
// Three registered multiply stages forming coord * f1 * f2 * f3 exactly for one term.
// Depends on cci_pkg.
`default_nettype none

module cci_term_mul (
  input  wire logic              clk,
  input  wire logic [2:0]        ld,
  input  wire cci_pkg::cci_term_t term,
  output cci_pkg::acc_t          prod
);
  import cci_pkg::*;

  localparam int M1_W = COORD_WIDTH + 1 + FACT_WIDTH + 1;
  localparam int M2_W = M1_W + FACT_WIDTH + 1;
  localparam int M3_W = M2_W + FACT_WIDTH + 1;

  logic signed [M1_W-1:0] m1_full;
  logic signed [M2_W-1:0] m2_full;
  logic signed [M3_W-1:0] m3_full;

  logic signed [M1_W-1:0] m1;
  logic signed [M2_W-1:0] m2;
  logic [FACT_WIDTH-1:0]  f2_d1;
  logic [FACT_WIDTH-1:0]  f3_d1;
  logic [FACT_WIDTH-1:0]  f3_d2;

  always_comb begin
    m1_full = term.coord * $signed({1'b0, term.f1});
    m2_full = m1 * $signed({1'b0, f2_d1});
    m3_full = m2 * $signed({1'b0, f3_d2});
  end

  // true product never exceeds 2^(COORD_WIDTH-1+3*FRAC_BITS), so the top bits are sign copies
  always_ff @(posedge clk) begin
    if (ld[0]) begin
      m1    <= m1_full;
      f2_d1 <= term.f2;
      f3_d1 <= term.f3;
    end
    if (ld[1]) begin
      m2    <= m2_full;
      f3_d2 <= f3_d1;
    end
    if (ld[2]) begin
      prod <= m3_full[ACC_WIDTH-1:0];
    end
  end

endmodule

`default_nettype wire

>>> hdl/cci_sum_round.sv
// Adds the four weighted terms, rounds to nearest (ties up) and saturates.
// Three register stages: pair sums, total with rounding, saturation into the result register.
// Depends on cci_pkg.
`default_nettype none

module cci_sum_round (
  input  wire logic                                clk,
  input  wire logic [2:0]                          ld,
  input  wire cci_pkg::acc_t [cci_pkg::NUM_TERMS-1:0] prod,
  output cci_pkg::cci_out_t                        result
);
  import cci_pkg::*;

  localparam logic signed [ACC_WIDTH-1:0] HALF =
    {{(ACC_WIDTH-2*FRAC_BITS){1'b0}}, 1'b1, {(2*FRAC_BITS-1){1'b0}}};
  localparam logic signed [QUOT_WIDTH-1:0] QMAX =
    {{(QUOT_WIDTH-COORD_WIDTH+1){1'b0}}, {(COORD_WIDTH-1){1'b1}}};
  localparam logic signed [QUOT_WIDTH-1:0] QMIN =
    {{(QUOT_WIDTH-COORD_WIDTH+1){1'b1}}, {(COORD_WIDTH-1){1'b0}}};

  logic signed [ACC_WIDTH-1:0]  s01;
  logic signed [ACC_WIDTH-1:0]  s23;
  logic signed [ACC_WIDTH-1:0]  total;
  logic signed [QUOT_WIDTH-1:0] quot;
  cci_out_t                     result_next;

  always_comb begin
    total = s01 + s23 + HALF;
    if (quot > QMAX) begin
      result_next.value   = {1'b0, {(COORD_WIDTH-1){1'b1}}};
      result_next.clipped = 1'b1;
    end else if (quot < QMIN) begin
      result_next.value   = {1'b1, {(COORD_WIDTH-1){1'b0}}};
      result_next.clipped = 1'b1;
    end else begin
      result_next.value   = quot[COORD_WIDTH-1:0];
      result_next.clipped = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ld[0]) begin
      s01 <= $signed(prod[0]) + $signed(prod[1]);
      s23 <= $signed(prod[2]) + $signed(prod[3]);
    end
    if (ld[1]) begin
      // arithmetic drop of the 2*FRAC_BITS extra fraction bits
      quot <= total[ACC_WIDTH-1:2*FRAC_BITS];
    end
    if (ld[2]) begin
      result <= result_next;
    end
  end

endmodule

`default_nettype wire

>>> hdl/cubic_curve_interpolator.sv
// Cubic curve interpolator: evaluates one coordinate (signed Q16.16) of a linear, cubic Bezier
// or cubic Hermite curve at t (Q1.16, values above one act as one) per item. The pipeline
// accepts one item every cycle unless a stalled output has filled every stage; each result passes
// through factor prep, the three chained multiplies per term, two adder stages and the saturation
// stage. Stages advance independently, so bubbles close up while the output is stalled.
// Results are exact, rounded to nearest with ties up, and saturated with clipped set.
`default_nettype none

module cubic_curve_interpolator (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              item_valid,
  output logic                   item_stall,
  input  wire cci_pkg::cci_in_t  item,
  output logic                   result_valid,
  input  wire logic              result_stall,
  output cci_pkg::cci_out_t      result
);
  import cci_pkg::*;

  logic [NUM_STAGES-1:0] vld;
  logic [NUM_STAGES-1:0] rdy;
  cci_term_t [NUM_TERMS-1:0] terms;
  acc_t [NUM_TERMS-1:0]      prod;

  // a stage loads when it is empty or its content moves on this cycle
  always_comb begin
    rdy[NUM_STAGES-1] = !vld[NUM_STAGES-1] || !result_stall;
    for (int i = NUM_STAGES - 2; i >= 0; i--) begin
      rdy[i] = !vld[i] || rdy[i+1];
    end
  end

  assign item_stall   = !rdy[0];
  assign result_valid = vld[NUM_STAGES-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (rdy[0]) begin
        vld[0] <= item_valid;
      end
      for (int i = 1; i < NUM_STAGES; i++) begin
        if (rdy[i]) begin
          vld[i] <= vld[i-1];
        end
      end
    end
  end

  cci_weights u_weights (
    .clk   (clk),
    .ld    (rdy[0]),
    .item  (item),
    .terms (terms)
  );

  for (genvar g = 0; g < NUM_TERMS; g++) begin : g_term
    cci_term_mul u_mul (
      .clk  (clk),
      .ld   (rdy[3:1]),
      .term (terms[g]),
      .prod (prod[g])
    );
  end

  cci_sum_round u_sum (
    .clk    (clk),
    .ld     (rdy[6:4]),
    .prod   (prod),
    .result (result)
  );

endmodule

`default_nettype wire

>>> test/cci_curve_checker.sv
// Scoreboard for the cubic curve interpolator: watches both channels, predicts each
// point from the accepted item and compares it with the delivered result.
// Depends on cci_pkg for payload types, command codes and widths.
`default_nettype none

module cci_curve_checker (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              item_valid,
  input  wire logic              item_stall,
  input  wire cci_pkg::cci_in_t  item,
  input  wire logic              result_valid,
  input  wire logic              result_stall,
  input  wire cci_pkg::cci_out_t result,
  output int                     mismatches,
  output int                     outstanding
);
  timeunit 1ns;
  timeprecision 1ps;
  import cci_pkg::*;

  localparam logic [63:0]         UNIT    = 64'd1 << FRAC_BITS;
  localparam logic signed [127:0] VAL_MAX = (128'sd1 <<< (COORD_WIDTH - 1)) - 128'sd1;
  localparam logic signed [127:0] VAL_MIN = -(128'sd1 <<< (COORD_WIDTH - 1));
  localparam logic signed [127:0] HALF_LSB = 128'sd1 <<< (2 * FRAC_BITS - 1);

  cci_out_t expected_points[$];
  int fail_count = 0;
  int queued = 0;

  assign mismatches  = fail_count;
  assign outstanding = queued;

  // Exact basis-weighted sum, weights scaled by 2^(3*FRAC_BITS), then round half up
  // and saturate.
  function automatic cci_out_t curve_point(input cci_in_t x);
    logic [63:0]         t, u;
    logic [63:0]         wt [4];
    logic signed [127:0] w [4];
    logic signed [127:0] c [4];
    logic signed [127:0] acc, q;
    cci_out_t            r;
    r = '0;
    t = 64'(x.blend);
    if (t > UNIT) t = UNIT;
    u = UNIT - t;
    case (x.command)
      CMD_LERP: begin
        wt[0] = u * UNIT * UNIT;
        wt[1] = t * UNIT * UNIT;
        wt[2] = 64'd0;
        wt[3] = 64'd0;
      end
      CMD_BEZIER: begin
        wt[0] = u * u * u;
        wt[1] = 64'd3 * t * u * u;
        wt[2] = 64'd3 * t * t * u;
        wt[3] = t * t * t;
      end
      CMD_HERMITE: begin
        wt[0] = u * u * (UNIT + 64'd2 * t);
        wt[1] = t * u * u;
        wt[2] = t * t * u;
        wt[3] = t * t * (64'd3 * UNIT - 64'd2 * t);
      end
      default: return r;
    endcase
    for (int i = 0; i < 4; i++) w[i] = $signed({64'd0, wt[i]});
    // in-tangent enters the Hermite sum with a minus sign
    if (x.command == CMD_HERMITE) w[2] = -w[2];
    c[0] = $signed(x.point_a);
    c[1] = $signed(x.point_b);
    c[2] = $signed(x.point_c);
    c[3] = $signed(x.point_d);
    acc = c[0] * w[0] + c[1] * w[1] + c[2] * w[2] + c[3] * w[3];
    q = (acc + HALF_LSB) >>> (2 * FRAC_BITS);
    if (q > VAL_MAX) begin
      r.value   = VAL_MAX[COORD_WIDTH-1:0];
      r.clipped = 1'b1;
    end else if (q < VAL_MIN) begin
      r.value   = VAL_MIN[COORD_WIDTH-1:0];
      r.clipped = 1'b1;
    end else begin
      r.value   = q[COORD_WIDTH-1:0];
      r.clipped = 1'b0;
    end
    return r;
  endfunction

  task automatic note_mismatch(input string what, input cci_out_t want, input cci_out_t got);
    fail_count++;
    if (fail_count <= 10)
      $display("[%0t] mismatch on %s: expected value=%h clipped=%b, got value=%h clipped=%b",
               $realtime, what, want.value, want.clipped, got.value, got.clipped);
  endtask

  always @(posedge clk) begin
    cci_out_t want;
    if (!rst) begin
      if (item_valid && !item_stall)
        expected_points.push_back(curve_point(item));
      if (result_valid && !result_stall) begin
        if (expected_points.size() == 0) begin
          note_mismatch("unexpected result", '0, result);
        end else begin
          want = expected_points.pop_front();
          if (result.value !== want.value)
            note_mismatch("value", want, result);
          if (result.clipped !== want.clipped)
            note_mismatch("clipped", want, result);
        end
      end
    end
    queued = expected_points.size();
  end

endmodule

`default_nettype wire

>>> test/cubic_curve_interpolator_tb.sv
// Top of the cubic curve interpolator regression: clock, reset, item stimulus,
// result back-pressure, watchdog and verdict. Checking lives in cci_curve_checker.
// Depends on cci_pkg, cci_curve_checker and cubic_curve_interpolator.
`default_nettype none

module cubic_curve_interpolator_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import cci_pkg::*;

  localparam int                     RANDOM_ITEMS   = 1750;
  localparam int                     WATCHDOG_LIMIT = 1000;
  localparam logic [1:0]             CMD_UNUSED     = 2'd3;
  localparam logic [COORD_WIDTH-1:0] C_MAX          = {1'b0, {(COORD_WIDTH-1){1'b1}}};
  localparam logic [COORD_WIDTH-1:0] C_MIN          = {1'b1, {(COORD_WIDTH-1){1'b0}}};
  localparam logic [FRAC_BITS:0]     T_ONE          = (FRAC_BITS+1)'(1 << FRAC_BITS);
  localparam logic [FRAC_BITS:0]     T_HALF         = (FRAC_BITS+1)'(1 << (FRAC_BITS - 1));
  localparam logic [FRAC_BITS:0]     T_TOP          = '1;

  logic     clk = 1'b0;
  logic     rst = 1'b1;
  logic     item_valid = 1'b0;
  logic     item_stall;
  cci_in_t  item = '0;
  logic     result_valid;
  logic     result_stall = 1'b0;
  cci_out_t result;
  int       mismatches;
  int       outstanding;

  int burst_left = 0;
  int stall_mode = 0;
  int stall_left = 0;
  int idle_cycles = 0;

  cubic_curve_interpolator dut (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .item         (item),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
  );

  cci_curve_checker scoreboard (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .item         (item),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result),
    .mismatches   (mismatches),
    .outstanding  (outstanding)
  );

  always #5 clk = ~clk;

  // Receiver back-pressure: phases of free flow, light, heavy and long stalls.
  always @(negedge clk) begin
    if (rst) begin
      result_stall <= 1'b0;
    end else begin
      if (stall_left == 0) begin
        stall_mode = $urandom_range(0, 3);
        stall_left = $urandom_range(20, 200);
      end else begin
        stall_left--;
      end
      case (stall_mode)
        0: result_stall <= 1'b0;
        1: result_stall <= ($urandom_range(0, 3) == 0);
        2: result_stall <= ($urandom_range(0, 1) != 0);
        default: result_stall <= ((stall_left % 32) < 24);
      endcase
    end
  end

  // Watchdog: too long without any transfer on either channel.
  always @(posedge clk) begin
    if (rst || (item_valid && !item_stall) || (result_valid && !result_stall)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("cubic_curve_interpolator regression: fail");
        $finish;
      end
    end
  end

  function automatic cci_in_t make_item(input logic [1:0] cmd,
                                        input logic [COORD_WIDTH-1:0] a, b, c, d,
                                        input logic [FRAC_BITS:0] t);
    cci_in_t x;
    x.command = cmd;
    x.point_a = a;
    x.point_b = b;
    x.point_c = c;
    x.point_d = d;
    x.blend   = t;
    return x;
  endfunction

  function automatic logic [COORD_WIDTH-1:0] rand_coord();
    int v;
    case ($urandom_range(0, 9))
      0: return C_MAX;
      1: return C_MIN;
      2, 3: begin
        v = $urandom_range(0, 1 << 20);
        return COORD_WIDTH'(v - (1 << 19));
      end
      default: return COORD_WIDTH'($urandom());
    endcase
  endfunction

  function automatic logic [FRAC_BITS:0] rand_blend();
    case ($urandom_range(0, 9))
      0: return ($urandom_range(0, 1) != 0) ? T_ONE : '0;
      1, 2: return (FRAC_BITS+1)'($urandom_range(int'(T_ONE) + 1, int'(T_TOP)));
      default: return (FRAC_BITS+1)'($urandom_range(0, int'(T_ONE)));
    endcase
  endfunction

  function automatic logic [1:0] rand_command();
    case ($urandom_range(0, 19))
      0: return CMD_UNUSED;
      1, 2, 3, 4, 5, 6: return CMD_LERP;
      7, 8, 9, 10, 11, 12: return CMD_BEZIER;
      default: return CMD_HERMITE;
    endcase
  endfunction

  // One transfer in; the sender may pause between bursts of random length.
  task automatic send_item(input cci_in_t x);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 60);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap > 0) begin
        item_valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    burst_left--;
    item       <= x;
    item_valid <= 1'b1;
    do @(posedge clk); while (item_stall);
    @(negedge clk);
  endtask

  initial begin
    repeat (6) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // directed: extremes, ties, clamped t, saturation both ways, unused command
    send_item(make_item(CMD_LERP, C_MIN, C_MAX, C_MAX, C_MIN, '0));
    send_item(make_item(CMD_LERP, C_MIN, C_MAX, C_MIN, C_MAX, T_HALF));
    send_item(make_item(CMD_LERP, C_MIN, C_MAX, '0, '0, T_ONE));
    send_item(make_item(CMD_LERP, '0, 'd1, '0, '0, T_HALF));
    send_item(make_item(CMD_LERP, '0, '1, '0, '0, T_HALF));
    send_item(make_item(CMD_LERP, C_MAX, C_MIN, '0, '0, T_TOP));
    send_item(make_item(CMD_LERP, C_MAX, C_MIN, '1, '1, (FRAC_BITS+1)'(T_ONE + 1)));
    send_item(make_item(CMD_BEZIER, C_MAX, C_MAX, C_MAX, C_MAX, T_HALF));
    send_item(make_item(CMD_BEZIER, C_MIN, C_MIN, C_MIN, C_MIN, 'd21845));
    send_item(make_item(CMD_BEZIER, C_MAX, C_MIN, C_MAX, C_MIN, 'd1));
    send_item(make_item(CMD_BEZIER, C_MIN, C_MAX, C_MIN, C_MAX, (FRAC_BITS+1)'(T_ONE - 1)));
    send_item(make_item(CMD_BEZIER, 'd3, '1, 'd7, C_MAX, T_TOP));
    send_item(make_item(CMD_HERMITE, C_MAX, C_MAX, C_MIN, C_MAX, T_HALF));
    send_item(make_item(CMD_HERMITE, C_MIN, C_MIN, C_MAX, C_MIN, T_HALF));
    send_item(make_item(CMD_HERMITE, C_MAX, C_MIN, C_MAX, C_MIN, '0));
    send_item(make_item(CMD_HERMITE, C_MAX, C_MIN, C_MAX, C_MIN, T_ONE));
    send_item(make_item(CMD_HERMITE, 'd65536, C_MAX, C_MAX, '1, T_TOP));
    send_item(make_item(CMD_HERMITE, '0, 'd1, '1, '0, 'd1));
    send_item(make_item(CMD_UNUSED, C_MAX, C_MIN, C_MAX, C_MIN, T_HALF));
    send_item(make_item(CMD_UNUSED, '1, '1, '1, '1, T_TOP));

    for (int n = 0; n < RANDOM_ITEMS; n++)
      send_item(make_item(rand_command(), rand_coord(), rand_coord(), rand_coord(),
                          rand_coord(), rand_blend()));
    item_valid <= 1'b0;

    while (outstanding != 0) @(posedge clk);
    repeat (4 * NUM_STAGES) @(posedge clk);

    if (mismatches == 0 && outstanding == 0)
      $display("cubic_curve_interpolator regression: pass");
    else
      $display("cubic_curve_interpolator regression: fail");
    $finish;
  end

endmodule

`default_nettype wire
